FILE: rtl/glyph_row_expand_embolden_unit_macros.svh
// ---------------------------------------------------------------------------
// Glyph row expander assertion macros
// Shared concurrent assertion helpers for the glyph row expander.
// ---------------------------------------------------------------------------
`ifndef GLYPH_ROW_EXPAND_EMBOLDEN_UNIT_MACROS_SVH
`define GLYPH_ROW_EXPAND_EMBOLDEN_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GREXP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GREXP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GREXP_ASSERT(name, clk, rst, prop, msg)
`define GREXP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: rtl/grexp_pkg.sv
// ---------------------------------------------------------------------------
// Glyph row expander package
// Widths, codes, shared types and pixel expansion functions.
// ---------------------------------------------------------------------------
`default_nettype none

package grexp_pkg;

   localparam int BYTE_W          = 8;
   localparam int PIX_W           = 8;
   localparam int FMT_W           = 2;
   localparam int MAX_ROW_PIXELS  = 256;
   localparam int MAX_BOLD_PASSES = 8;
   localparam int PREV_SLOTS      = 8;
   localparam int COL_W           = 9;
   localparam int PASS_W          = 3;
   localparam int ITALIC_W        = 4;
   localparam int SRC_CNT_W       = 4;
   localparam int PAD_W           = 5;
   localparam int REM_W           = 6;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 9;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [FMT_W-1:0] {
      FMT_1BPP = 2'd0,
      FMT_2BPP = 2'd1,
      FMT_4BPP = 2'd2,
      FMT_8BPP = 2'd3
   } fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_FORMAT = 3'd0,
      CSR_MONO_OUTPUT   = 3'd1,
      CSR_ROW_WIDTH     = 3'd2,
      CSR_BOLD_PASSES   = 3'd3,
      CSR_ITALIC_EXTRA  = 3'd4
   } csr_idx_type;

   typedef struct packed {
      fmt_type               source_format;
      logic                  mono_output;
      logic [COL_W-1:0]      width;
      logic [PASS_W-1:0]     passes;
      logic [ITALIC_W-1:0]   italic_extra;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     source_byte;
      logic [SRC_CNT_W-1:0]  src_count;
      logic [PAD_W-1:0]      pad_count;
      logic                  row_end;
   } entry_type;

   typedef struct packed {
      logic                  full;
      logic                  empty;
      logic [QCNT_W-1:0]     count;
   } qstat_type;

   typedef struct packed {
      logic                  busy;
      logic                  emit;
   } back_stat_type;

   function automatic logic [PIX_W-1:0] cov2(input logic [1:0] v);
      logic [PIX_W-1:0] res;
      case (v)
         2'd0:    res = 8'd0;
         2'd1:    res = 8'd84;
         2'd2:    res = 8'd169;
         default: res = 8'd255;
      endcase
      return res;
   endfunction

   function automatic logic [PIX_W-1:0] cov4(input logic [3:0] v);
      logic [PIX_W-1:0] res;
      if (v == 4'd0) begin
         res = 8'd0;
      end else if (v == 4'd15) begin
         res = 8'd255;
      end else begin
         res = 8'(({4'd0, v} << 4) + {4'd0, v} - 8'd1);
      end
      return res;
   endfunction

   function automatic logic [PIX_W-1:0] expand_pixel(input fmt_type fmt, input logic mono,
                                                     input logic [BYTE_W-1:0] src,
                                                     input logic [2:0] k);
      logic [2:0]        sh;
      logic [BYTE_W-1:0] fld;
      logic [PIX_W-1:0]  res;
      sh  = 3'(k << fmt);
      fld = src << sh;
      if (mono) begin
         res = {7'd0, fld[7]};
      end else begin
         unique case (fmt)
            FMT_1BPP: res = fld[7] ? 8'hFF : 8'h00;
            FMT_2BPP: res = cov2(fld[7:6]);
            FMT_4BPP: res = cov4(fld[7:4]);
            FMT_8BPP: res = src;
            default:  res = src;
         endcase
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/grexp_if.sv
// ---------------------------------------------------------------------------
// Glyph row expander channels
// Request and response channel interfaces with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface grexp_req_if;
   logic                         valid;
   logic                         ready;
   logic [grexp_pkg::BYTE_W-1:0] source_byte;
   logic                         row_end;

   modport source (output valid, output source_byte, output row_end, input ready);
   modport sink   (input valid, input source_byte, input row_end, output ready);
endinterface

interface grexp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [grexp_pkg::PIX_W-1:0] pixel;
   logic                        last;

   modport source (output valid, output pixel, output last, input ready);
   modport sink   (input valid, input pixel, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/glyph_row_expand_embolden_unit.sv
// ---------------------------------------------------------------------------
// Glyph row expander with bold smear
// Unpacks 1, 2, 4 or 8 bit per pixel glyph rows into coverage or mono
// pixels, applies bold smear passes and pads each row.
//
//   Channel    Direction  Carries
//   req_chan   in         source_byte, row_end
//   rsp_chan   out        pixel, last
//   csr_*      in         register write: enable, index, data
//
// The front end takes one request per cycle while the queue has room.
// The back end emits up to 8 >> source_format source pixels per request,
// fewer once the row width is reached, plus bold_passes + italic_extra
// padding pixels at row end. A request that emits nothing is retired as
// it is popped. Reset is synchronous. A stalled response holds the back
// end while the front end fills the two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none
`include "glyph_row_expand_embolden_unit_macros.svh"

module glyph_row_expand_embolden_unit (
   input  logic                                clock,
   input  logic                                reset,
   grexp_req_if.sink                           req_chan,
   grexp_rsp_if.source                         rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [grexp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [grexp_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import grexp_pkg::*;

   fmt_type              fmt_ff;
   logic                 mono_ff;
   logic [COL_W-1:0]     row_width_ff;
   logic [PASS_W-1:0]    passes_ff;
   logic [ITALIC_W-1:0]  italic_ff;

   cfg_type              cfg;
   logic                 push;
   entry_type            push_entry;
   entry_type            pop_entry;
   logic                 pop;
   qstat_type            qstat;
   back_stat_type        bstat;

   always_comb begin
      cfg.source_format = fmt_ff;
      cfg.mono_output   = mono_ff;
      cfg.passes        = passes_ff;
      cfg.italic_extra  = italic_ff;
      if (row_width_ff == '0) begin
         cfg.width = COL_W'(1);
      end else if (row_width_ff > COL_W'(MAX_ROW_PIXELS)) begin
         cfg.width = COL_W'(MAX_ROW_PIXELS);
      end else begin
         cfg.width = row_width_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_1BPP;
         mono_ff      <= 1'b0;
         row_width_ff <= COL_W'(8);
         passes_ff    <= '0;
         italic_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SOURCE_FORMAT: fmt_ff       <= fmt_type'(csr_write_data[FMT_W-1:0]);
            CSR_MONO_OUTPUT:   mono_ff      <= csr_write_data[0];
            CSR_ROW_WIDTH:     row_width_ff <= csr_write_data[COL_W-1:0];
            CSR_BOLD_PASSES:   passes_ff    <= csr_write_data[PASS_W-1:0];
            CSR_ITALIC_EXTRA:  italic_ff    <= csr_write_data[ITALIC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   grexp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   grexp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   grexp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .entry    (pop_entry),
      .qstat    (qstat),
      .pop      (pop),
      .bstat    (bstat),
      .rsp_chan (rsp_chan)
   );

   `GREXP_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_chan.valid, "Valid after reset")
   `GREXP_ASSERT(a_queue_bound, clock, reset, qstat.count <= QCNT_W'(QUEUE_DEPTH), "Queue overfilled")
   `GREXP_ASSERT(a_rsp_from_busy, clock, reset, $rose(rsp_chan.valid) |-> $past(bstat.busy), "No work")
   `GREXP_ASSERT(a_pop_not_empty, clock, reset, pop |-> !qstat.empty, "Pop from empty queue")
   `GREXP_ASSERT(a_emit_to_rsp, clock, reset, bstat.emit |=> rsp_chan.valid, "Emitted pixel lost")

endmodule

`default_nettype wire

FILE: rtl/grexp_front.sv
// ---------------------------------------------------------------------------
// Glyph row expander front end
// Accepts source bytes, tracks the row column and works out how many
// source and padding pixels each request produces.
// ---------------------------------------------------------------------------
`default_nettype none

module grexp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  grexp_pkg::cfg_type    cfg,
   grexp_req_if.sink             req_chan,
   input  grexp_pkg::qstat_type  qstat,
   output logic                  push,
   output grexp_pkg::entry_type  push_entry
);
   import grexp_pkg::*;

   logic [COL_W-1:0]     col_ff;
   logic [COL_W-1:0]     col_in;
   logic [SRC_CNT_W-1:0] per_byte;
   logic [COL_W-1:0]     room;
   logic [SRC_CNT_W-1:0] src_count;
   logic [PAD_W-1:0]     pad;

   assign req_chan.ready = !qstat.full;
   assign push           = req_chan.valid && !qstat.full;

   always_comb begin
      per_byte  = SRC_CNT_W'(4'd8 >> cfg.source_format);
      room      = (col_ff >= cfg.width) ? '0 : cfg.width - col_ff;
      src_count = (room < COL_W'(per_byte)) ? room[SRC_CNT_W-1:0] : per_byte;
      pad       = PAD_W'(cfg.passes) + PAD_W'(cfg.italic_extra);

      push_entry.source_byte = req_chan.source_byte;
      push_entry.src_count   = src_count;
      push_entry.pad_count   = req_chan.row_end ? pad : '0;
      push_entry.row_end     = req_chan.row_end;

      col_in = col_ff;
      if (push) begin
         col_in = req_chan.row_end ? '0 : col_ff + COL_W'(src_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/grexp_queue.sv
// ---------------------------------------------------------------------------
// Glyph row expander request queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module grexp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  grexp_pkg::entry_type  push_entry,
   input  logic                  pop,
   output grexp_pkg::entry_type  pop_entry,
   output grexp_pkg::qstat_type  qstat
);
   import grexp_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_in;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign qstat.count = count_ff;
   assign pop_entry   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/grexp_back.sv
// ---------------------------------------------------------------------------
// Glyph row expander back end
// Emits one pixel per cycle while busy and the response is not stalled:
// expansion, bold smear passes and padding, with a registered response stage.
// ---------------------------------------------------------------------------
`default_nettype none

module grexp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  grexp_pkg::cfg_type        cfg,
   input  grexp_pkg::entry_type      entry,
   input  grexp_pkg::qstat_type      qstat,
   output logic                      pop,
   output grexp_pkg::back_stat_type  bstat,
   grexp_rsp_if.source               rsp_chan
);
   import grexp_pkg::*;

   logic                 busy_ff,     busy_in;
   logic [BYTE_W-1:0]    byte_ff,     byte_in;
   logic [SRC_CNT_W-1:0] src_left_ff, src_left_in;
   logic [2:0]           k_ff,        k_in;
   logic [PAD_W-1:0]     pad_left_ff, pad_left_in;
   logic                 end_ff,      end_in;
   logic [PIX_W-1:0]     prev_ff [PREV_SLOTS];
   logic [PIX_W-1:0]     prev_in [PREV_SLOTS];
   logic [PIX_W-1:0]     prev_upd [PREV_SLOTS];
   logic                 out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]     out_pixel_ff, out_pixel_in;
   logic                 out_last_ff,  out_last_in;

   logic                 emit;
   logic                 finish;
   logic                 from_src;
   logic                 entry_empty;
   logic                 clear_prev;
   logic [REM_W-1:0]     remaining;
   logic [PIX_W-1:0]     pix_src;
   logic [PIX_W-1:0]     smeared;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.pixel = out_pixel_ff;
   assign rsp_chan.last  = out_last_ff;
   assign bstat.busy     = busy_ff;
   assign bstat.emit     = emit;

   assign emit        = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign remaining   = REM_W'(src_left_ff) + REM_W'(pad_left_ff);
   assign finish      = emit && (remaining == REM_W'(1));
   assign pop         = !qstat.empty && (!busy_ff || finish);
   assign from_src    = (src_left_ff != '0);
   assign entry_empty = (entry.src_count == '0) && (entry.pad_count == '0);
   assign clear_prev  = (finish && end_ff) || (pop && entry_empty && entry.row_end);
   assign pix_src     = from_src ? expand_pixel(cfg.source_format, cfg.mono_output,
                                                byte_ff, k_ff) : '0;

   always_comb begin
      logic [PIX_W-1:0] v;
      logic [PIX_W:0]   sum;
      v = pix_src;
      for (int p = 0; p < PREV_SLOTS; p++) begin
         prev_upd[p] = prev_ff[p];
         sum         = {1'b0, v} + {1'b0, prev_ff[p]};
         if (p < int'(cfg.passes)) begin
            prev_upd[p] = v;
            if (cfg.mono_output) begin
               v = v | prev_ff[p];
            end else begin
               v = sum[PIX_W] ? '1 : sum[PIX_W-1:0];
            end
         end
      end
      smeared = v;
   end

   always_comb begin
      busy_in     = busy_ff;
      byte_in     = byte_ff;
      src_left_in = src_left_ff;
      k_in        = k_ff;
      pad_left_in = pad_left_ff;
      end_in      = end_ff;
      if (emit) begin
         if (from_src) begin
            src_left_in = src_left_ff - 1'b1;
            k_in        = k_ff + 1'b1;
         end else begin
            pad_left_in = pad_left_ff - 1'b1;
         end
      end
      if (finish) begin
         busy_in = 1'b0;
      end
      if (pop) begin
         busy_in     = !entry_empty;
         byte_in     = entry.source_byte;
         src_left_in = entry.src_count;
         pad_left_in = entry.pad_count;
         end_in      = entry.row_end;
         k_in        = '0;
      end

      for (int p = 0; p < PREV_SLOTS; p++) begin
         prev_in[p] = emit ? prev_upd[p] : prev_ff[p];
         if (clear_prev) begin
            prev_in[p] = '0;
         end
      end

      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_pixel_in = smeared;
         out_last_in  = end_ff && (remaining == REM_W'(1));
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      src_left_ff  <= src_left_in;
      k_ff         <= k_in;
      pad_left_ff  <= pad_left_in;
      end_ff       <= end_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int p = 0; p < PREV_SLOTS; p++) begin
            prev_ff[p] <= '0;
         end
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         for (int p = 0; p < PREV_SLOTS; p++) begin
            prev_ff[p] <= prev_in[p];
         end
      end
   end

endmodule

`default_nettype wire

FILE: sim/glyph_row_expand_embolden_unit_tb.sv
// ---------------------------------------------------------------------------
// Glyph row expander testbench
// Drives packed glyph source bytes through the request channel under many
// register settings and checks every emitted pixel against a local prediction
// of unpacking, bold smear and row padding or a case's typed pixel. A short
// directed table leads, then random rows with random idling on both channels.
// ---------------------------------------------------------------------------
module glyph_row_expand_embolden_unit_tb;
   import grexp_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_ITEMS  = 230;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } pixel_beat_type;

   typedef struct {
      fmt_type           fmt;
      logic              mono;
      logic [COL_W-1:0]  width;
      logic [PASS_W-1:0] passes;
      logic [ITALIC_W-1:0] italic;
      logic [BYTE_W-1:0] src;
      logic              row_end;
      bit                typed;
      logic [PIX_W-1:0]  exp_pixel;
      int                exp_count;
   } glyph_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   grexp_req_if req_chan ();
   grexp_rsp_if rsp_chan ();

   glyph_row_expand_embolden_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Register copies and row state of the expected behaviour.
   fmt_type             cfg_format = FMT_1BPP;
   logic                cfg_mono   = 1'b0;
   logic [COL_W-1:0]    cfg_width  = 9'd8;
   logic [PASS_W-1:0]   cfg_passes = '0;
   logic [ITALIC_W-1:0] cfg_italic = '0;
   int                  row_column = 0;
   logic [PIX_W-1:0]    stage_prev [PREV_SLOTS];

   pixel_beat_type awaited_pixels [$];
   pixel_beat_type step_pixels [$];
   glyph_case_type directed_cases [$];

   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int error_count = 0;
   int checked_count = 0;
   int accepted_count = 0;
   int rows_closed = 0;
   int config_count = 0;
   int cycle_count = 0;

   function automatic logic [PIX_W-1:0] expand_source(input logic [BYTE_W-1:0] src,
                                                      input int k);
      int v;
      int res;
      case (cfg_format)
         FMT_1BPP: begin
            v   = (src >> (7 - k)) & 1;
            res = cfg_mono ? v : (v != 0 ? 255 : 0);
         end
         FMT_2BPP: begin
            v   = (src >> (6 - 2 * k)) & 3;
            res = cfg_mono ? int'(v >= 2) : (v != 0 ? 256 * v / 3 - 1 : 0);
         end
         FMT_4BPP: begin
            v   = (src >> (4 - 4 * k)) & 15;
            res = cfg_mono ? int'(v >= 8) : (v != 0 ? 256 * v / 15 - 1 : 0);
         end
         default: begin
            res = cfg_mono ? int'(src >= 8'h80) : int'(src);
         end
      endcase
      return PIX_W'(res);
   endfunction

   function automatic logic [PIX_W-1:0] smear_bold(input logic [PIX_W-1:0] pix);
      int v;
      int s;
      int stages;
      v      = int'(pix);
      stages = (cfg_passes > MAX_BOLD_PASSES) ? MAX_BOLD_PASSES : int'(cfg_passes);
      for (int p = 0; p < stages; p++) begin
         if (cfg_mono) begin
            s = v | int'(stage_prev[p]);
         end else begin
            s = v + int'(stage_prev[p]);
            if (s > 255) begin
               s = 255;
            end
         end
         stage_prev[p] = PIX_W'(v);
         v = s & 255;
      end
      return PIX_W'(v);
   endfunction

   task automatic predict_request(input logic [BYTE_W-1:0] src, input logic end_flag);
      int per_byte;
      int span;
      int pad;
      step_pixels.delete();
      per_byte = 8 >> int'(cfg_format);
      span = int'(cfg_width);
      if (span < 1) begin
         span = 1;
      end
      if (span > MAX_ROW_PIXELS) begin
         span = MAX_ROW_PIXELS;
      end
      for (int k = 0; k < per_byte; k++) begin
         if (row_column < span) begin
            step_pixels.push_back('{smear_bold(expand_source(src, k)), 1'b0});
            row_column++;
         end
      end
      if (end_flag) begin
         pad = int'(cfg_passes) + int'(cfg_italic);
         for (int i = 0; i < pad; i++) begin
            step_pixels.push_back('{smear_bold('0), 1'b0});
         end
         if (step_pixels.size() > 0) begin
            step_pixels[step_pixels.size() - 1].last = 1'b1;
         end
         row_column = 0;
         foreach (stage_prev[p]) begin
            stage_prev[p] = '0;
         end
      end
   endtask

   task automatic add_case(input fmt_type fmt, input int mono, input int width,
                           input int passes, input int italic, input logic [7:0] src,
                           input int row_end, input int typed, input int exp_pixel,
                           input int exp_count);
      glyph_case_type c;
      c.fmt       = fmt;
      c.mono      = 1'(mono);
      c.width     = COL_W'(width);
      c.passes    = PASS_W'(passes);
      c.italic    = ITALIC_W'(italic);
      c.src       = src;
      c.row_end   = 1'(row_end);
      c.typed     = 1'(typed);
      c.exp_pixel = PIX_W'(exp_pixel);
      c.exp_count = exp_count;
      directed_cases.push_back(c);
   endtask

   task automatic apply_config(input fmt_type fmt, input logic mono,
                               input logic [COL_W-1:0] width,
                               input logic [PASS_W-1:0] passes,
                               input logic [ITALIC_W-1:0] italic);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SOURCE_FORMAT;
      csr_write_data   <= CSR_DATA_W'(fmt);
      @(posedge clock);
      csr_index        <= CSR_MONO_OUTPUT;
      csr_write_data   <= CSR_DATA_W'(mono);
      @(posedge clock);
      csr_index        <= CSR_ROW_WIDTH;
      csr_write_data   <= CSR_DATA_W'(width);
      @(posedge clock);
      csr_index        <= CSR_BOLD_PASSES;
      csr_write_data   <= CSR_DATA_W'(passes);
      @(posedge clock);
      csr_index        <= CSR_ITALIC_EXTRA;
      csr_write_data   <= CSR_DATA_W'(italic);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_format = fmt;
      cfg_mono   = mono;
      cfg_width  = width;
      cfg_passes = passes;
      cfg_italic = italic;
      config_count++;
   endtask

   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      while (awaited_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_glyph_byte(input logic [BYTE_W-1:0] src, input logic end_flag,
                                  input bit typed, input logic [PIX_W-1:0] typed_pixel,
                                  input int typed_count);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.source_byte <= src;
      req_chan.row_end     <= end_flag;
      do @(posedge clock); while (!req_chan.ready);
      accepted_count++;
      if (end_flag) begin
         rows_closed++;
      end
      predict_request(src, end_flag);
      if (typed) begin
         for (int i = 0; i < typed_count; i++) begin
            awaited_pixels.push_back('{typed_pixel, end_flag && (i == typed_count - 1)});
         end
      end else begin
         foreach (step_pixels[i]) begin
            awaited_pixels.push_back(step_pixels[i]);
         end
      end
   endtask

   // Response side: random back-pressure, one draw per pixel.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      pixel_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         checked_count++;
         if (awaited_pixels.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("Unexpected pixel %0d last %0d with nothing awaited",
                        rsp_chan.pixel, rsp_chan.last);
            end
         end else begin
            want = awaited_pixels.pop_front();
            if (rsp_chan.pixel !== want.pixel || rsp_chan.last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("Pixel mismatch: expected pixel %0d last %0d, got pixel %0d last %0d",
                           want.pixel, want.last, rsp_chan.pixel, rsp_chan.last);
               end
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d pixels outstanding",
               cycle_count, awaited_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      glyph_case_type c;
      fmt_type     fmt;
      logic        mono;
      int          width;
      int          passes;
      int          italic;
      int          span;
      int          per_byte;
      int          row_bytes;
      int          sent;
      int          kind;
      int          count;
      bit          extreme;

      req_chan.valid       <= 1'b0;
      req_chan.source_byte <= '0;
      req_chan.row_end     <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_SOURCE_FORMAT;
      csr_write_data       <= '0;
      reset                <= 1'b1;
      foreach (stage_prev[p]) begin
         stage_prev[p] = '0;
      end

      add_case(FMT_1BPP, 0, 8, 0, 0, 8'hFF, 1, 1, 255, 8);
      add_case(FMT_1BPP, 0, 8, 0, 0, 8'h00, 1, 1, 0, 8);
      add_case(FMT_2BPP, 0, 8, 0, 0, 8'hFF, 0, 1, 255, 4);
      add_case(FMT_2BPP, 0, 8, 0, 0, 8'h1B, 1, 0, 0, 0);
      add_case(FMT_4BPP, 0, 8, 0, 0, 8'hFF, 0, 1, 255, 2);
      add_case(FMT_4BPP, 0, 8, 0, 0, 8'h18, 0, 0, 0, 0);
      add_case(FMT_4BPP, 0, 8, 0, 0, 8'h0F, 1, 0, 0, 0);
      add_case(FMT_8BPP, 0, 8, 0, 0, 8'hFF, 0, 1, 255, 1);
      add_case(FMT_8BPP, 0, 8, 0, 0, 8'h80, 0, 0, 0, 0);
      add_case(FMT_8BPP, 0, 8, 0, 0, 8'h7F, 1, 0, 0, 0);
      add_case(FMT_1BPP, 1, 8, 0, 0, 8'h5A, 1, 0, 0, 0);
      add_case(FMT_8BPP, 1, 8, 0, 0, 8'h80, 1, 1, 1, 1);
      add_case(FMT_8BPP, 1, 8, 0, 0, 8'h7F, 1, 1, 0, 1);
      add_case(FMT_2BPP, 1, 8, 0, 0, 8'hB4, 1, 0, 0, 0);
      add_case(FMT_4BPP, 1, 8, 0, 0, 8'h87, 0, 0, 0, 0);
      add_case(FMT_1BPP, 0, 8, 7, 15, 8'h80, 1, 0, 0, 0);
      add_case(FMT_1BPP, 0, 8, 7, 15, 8'h80, 1, 0, 0, 0);
      add_case(FMT_8BPP, 0, 2, 3, 2, 8'h90, 0, 0, 0, 0);
      add_case(FMT_8BPP, 0, 2, 3, 2, 8'hA0, 0, 0, 0, 0);
      add_case(FMT_8BPP, 0, 2, 3, 2, 8'h33, 0, 0, 0, 0);
      add_case(FMT_8BPP, 0, 2, 3, 2, 8'h44, 1, 0, 0, 0);
      add_case(FMT_1BPP, 0, 0, 0, 0, 8'hFF, 1, 1, 255, 1);
      add_case(FMT_1BPP, 0, 0, 0, 0, 8'h00, 0, 1, 0, 1);
      add_case(FMT_1BPP, 0, 0, 0, 0, 8'hFF, 1, 1, 0, 0);
      add_case(FMT_1BPP, 1, 511, 1, 0, 8'hC3, 1, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         c = directed_cases[i];
         if (c.fmt != cfg_format || c.mono != cfg_mono || c.width != cfg_width ||
             c.passes != cfg_passes || c.italic != cfg_italic) begin
            wait_until_drained();
            apply_config(c.fmt, c.mono, c.width, c.passes, c.italic);
         end
         send_glyph_byte(c.src, c.row_end, c.typed, c.exp_pixel, c.exp_count);
      end

      // Random phases: each picks a setting, then sends mostly whole rows.
      // A phase may stop inside a row, so the next setting applies mid-row.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         extreme = ($urandom_range(0, 3) == 0);
         fmt     = fmt_type'($urandom_range(0, 3));
         mono    = 1'($urandom_range(0, 1));
         if (extreme) begin
            passes = $urandom_range(0, 1) ? 7 : 0;
            italic = $urandom_range(0, 1) ? 15 : 0;
            width  = (fmt <= FMT_2BPP && $urandom_range(0, 1)) ? MAX_ROW_PIXELS : 1;
         end else begin
            passes = $urandom_range(0, 7);
            italic = $urandom_range(0, 15);
            if (fmt == FMT_1BPP && $urandom_range(0, 5) == 0) begin
               width = $urandom_range(25, 511);
            end else begin
               width = $urandom_range(0, 24);
            end
         end
         wait_until_drained();
         apply_config(fmt, mono, COL_W'(width), PASS_W'(passes), ITALIC_W'(italic));
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);

         span = (width < 1) ? 1 : (width > MAX_ROW_PIXELS ? MAX_ROW_PIXELS : width);
         per_byte  = 8 >> int'(fmt);
         row_bytes = (span + per_byte - 1) / per_byte;
         repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 9);
            case (kind)
               7:       count = $urandom_range(1, row_bytes);
               8:       count = row_bytes + $urandom_range(1, 3);
               9:       count = $urandom_range(1, row_bytes);
               default: count = row_bytes;
            endcase
            for (int b = 0; b < count; b++) begin
               send_glyph_byte(8'($urandom), (b == count - 1) && (kind != 9), 1'b0, '0, 0);
               sent++;
               if ($urandom_range(0, 39) == 0) begin
                  wait_until_drained();
               end
            end
         end
      end

      wait_until_drained();
      $display("Accepted %0d glyph byte requests (%0d closed rows) over %0d register settings,",
               accepted_count, rows_closed, config_count);
      $display("and checked %0d emitted pixels in %0d cycles.", checked_count, cycle_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/grexp_pkg.sv
rtl/grexp_if.sv
rtl/grexp_front.sv
rtl/grexp_queue.sv
rtl/grexp_back.sv
rtl/glyph_row_expand_embolden_unit.sv
sim/glyph_row_expand_embolden_unit_tb.sv
